@@ rtl/led_matrix_command_engine_unit_macros.svh @@
// ----------------------------------------------------------------------------
// LED matrix command engine assertion macros
// Shorthand for clocked, reset-qualified checks on clk_i / rst_ni.
// ----------------------------------------------------------------------------
`ifndef LED_MATRIX_COMMAND_ENGINE_UNIT_MACROS_SVH
`define LED_MATRIX_COMMAND_ENGINE_UNIT_MACROS_SVH

// same-cycle implication
`define LMCE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LMCE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/lmce_pkg.sv @@
// ----------------------------------------------------------------------------
// lmce_pkg
// Types, constants and lookup tables of the LED matrix command engine.
// ----------------------------------------------------------------------------
package lmce_pkg;

  localparam int ROWS = 5;
  localparam int COLS = 7;
  localparam int ROW_IDX_W = $clog2(ROWS);

  localparam logic [6:0] ROW_ALL_OFF = 7'h7F;
  localparam logic [6:0] COL_LEFT    = 7'h40;

  localparam int DVD_W = 7;
  localparam int DVS_W = 4;
  localparam logic [2:0] DIV_STEPS = 3'd7;
  localparam logic [DVS_W-1:0] DEC_BASE = 4'd10;

  typedef enum logic [2:0] {
    ACT_PLOT   = 3'd0,
    ACT_SET    = 3'd1,
    ACT_CLEAR  = 3'd2,
    ACT_SCAN   = 3'd3,
    ACT_NUMBER = 3'd4,
    ACT_LINE   = 3'd5,
    ACT_BLANK  = 3'd6
  } act_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } lmce_div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quot;
    logic [DVS_W-1:0] rem;
  } lmce_div_rsp_t;

  // active-low row select, index 0 is the top row
  function automatic logic [6:0] row_sel(input logic [2:0] idx);
    logic [6:0] w;
    case (idx)
      3'd0:    w = 7'h6F;
      3'd1:    w = 7'h77;
      3'd2:    w = 7'h7B;
      3'd3:    w = 7'h7D;
      3'd4:    w = 7'h7E;
      default: w = ROW_ALL_OFF;
    endcase
    return w;
  endfunction

  // column 1 is bit 6
  function automatic logic [6:0] col_bit(input logic [2:0] c);
    return COL_LEFT >> (c - 3'd1);
  endfunction

  // 3x5 digit font, bit 2 is the glyph's left column
  function automatic logic [2:0] glyph(input logic [3:0] d, input logic [2:0] r);
    logic [14:0] g;
    logic [2:0]  v;
    case (d)
      4'd0:    g = {3'd7, 3'd5, 3'd5, 3'd5, 3'd7};
      4'd1:    g = {3'd2, 3'd6, 3'd2, 3'd2, 3'd7};
      4'd2:    g = {3'd2, 3'd5, 3'd1, 3'd2, 3'd7};
      4'd3:    g = {3'd6, 3'd1, 3'd6, 3'd1, 3'd6};
      4'd4:    g = {3'd5, 3'd5, 3'd7, 3'd1, 3'd1};
      4'd5:    g = {3'd7, 3'd4, 3'd6, 3'd1, 3'd6};
      4'd6:    g = {3'd3, 3'd4, 3'd7, 3'd5, 3'd7};
      4'd7:    g = {3'd7, 3'd1, 3'd1, 3'd2, 3'd2};
      4'd8:    g = {3'd7, 3'd5, 3'd7, 3'd5, 3'd7};
      4'd9:    g = {3'd7, 3'd5, 3'd7, 3'd1, 3'd6};
      default: g = '0;
    endcase
    case (r)
      3'd0:    v = g[14:12];
      3'd1:    v = g[11:9];
      3'd2:    v = g[8:6];
      3'd3:    v = g[5:3];
      3'd4:    v = g[2:0];
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/lmce_div.sv @@
// ----------------------------------------------------------------------------
// lmce_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lmce_div import lmce_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  lmce_div_req_t req_i,
  output lmce_div_rsp_t rsp_o
);

  logic [DVD_W-1:0] dvd_q, dvd_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVD_W-1:0] quo_q, quo_d;
  logic [2:0]       cnt_q, cnt_d;
  logic             done_q, done_d;

  logic [DVS_W:0] trial;
  logic [DVS_W:0] diff;
  logic           fits;

  assign trial = {rem_q, dvd_q[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (req_i.start) begin
      dvd_d = req_i.dividend;
      dvs_d = req_i.divisor;
      rem_d = '0;
      quo_d = '0;
      cnt_d = DIV_STEPS;
    end else if (cnt_q != 3'd0) begin
      dvd_d  = {dvd_q[DVD_W-2:0], 1'b0};
      rem_d  = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo_d  = {quo_q[DVD_W-2:0], fits};
      cnt_d  = cnt_q - 3'd1;
      done_d = (cnt_q == 3'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

@@ rtl/led_matrix_command_engine_unit.sv @@
// ----------------------------------------------------------------------------
// led_matrix_command_engine_unit
// Command engine for a 5x7 row-scanned LED matrix with a frame store.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+------------------------------------------
//  in      | in_valid_i / in_stall_o | action, row, col, row_end, col_end, number
//  out     | out_valid_o / out_stall_i | row_word, col_word, last
//
//  One command at a time; in_stall_o is high until its last beat is taken.
//  Plot, blank, scan: first beat in the cycle after accept, then one beat a
//  cycle while out_stall_i is low. Number: the shared divider runs first, then
//  11 beats follow: units glyph rows, tens glyph rows, a blank word.
//  Line: each column runs the divider before its beat; vertical is one pixel.
//  Set / clear only write the frame store. Reset clears the frame store at once.
// ----------------------------------------------------------------------------
`include "led_matrix_command_engine_unit_macros.svh"

module led_matrix_command_engine_unit import lmce_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] action_i,
  input  logic [2:0] row_i,
  input  logic [2:0] col_i,
  input  logic [2:0] row_end_i,
  input  logic [2:0] col_end_i,
  input  logic [6:0] number_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [6:0] row_word_o,
  output logic [6:0] col_word_o,
  output logic       last_o
);

  state_e state_q, state_d;
  act_e   act_q, act_d;
  logic [2:0] row_q, row_d, col_q, col_d, cend_q, cend_d;
  logic [2:0] drmag_q, drmag_d;
  logic       neg_q, neg_d;
  logic [3:0] idx_q, idx_d;
  logic [COLS-1:0] frame_q [ROWS];
  logic [COLS-1:0] frame_d [ROWS];

  lmce_div_req_t div_req;
  lmce_div_rsp_t div_rsp;

  logic in_fire, out_fire;
  logic pix_ok, line_ok;
  logic [ROW_IDX_W-1:0] wr_idx;
  logic [2:0] k_next;
  logic [2:0] line_c;
  logic signed [8:0] line_r;
  logic [2:0] line_ri;
  logic [2:0] sub_idx;

  assign in_fire  = in_valid_i && !in_stall_o;
  assign out_fire = out_valid_o && !out_stall_i;

  assign pix_ok  = (row_i inside {[3'd1:3'd5]}) && (col_i inside {[3'd1:3'd7]});
  assign line_ok = pix_ok && (row_end_i inside {[3'd1:3'd5]})
                   && (col_end_i inside {[3'd1:3'd7]}) && (col_end_i >= col_i);
  assign wr_idx  = ROW_IDX_W'(row_i - 3'd1);
  assign k_next  = idx_q[2:0] + 3'd1;

  lmce_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (action_i)
            ACT_PLOT:   if (pix_ok) state_d = ST_EMIT;
            ACT_SCAN,
            ACT_BLANK:  state_d = ST_EMIT;
            ACT_NUMBER: if (number_i <= 7'd99) state_d = ST_DIV;
            ACT_LINE: begin
              if (line_ok) state_d = (col_end_i == col_i) ? ST_EMIT : ST_DIV;
            end
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_DIV:  if (div_rsp.done) state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_fire) begin
          if (last_o) state_d = ST_IDLE;
          else if (act_q == ACT_LINE) state_d = ST_DIV;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and divider control
  always_comb begin
    act_d   = act_q;
    row_d   = row_q;
    col_d   = col_q;
    cend_d  = cend_q;
    drmag_d = drmag_q;
    neg_d   = neg_q;
    idx_d   = idx_q;
    frame_d = frame_q;
    div_req = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          act_d   = act_e'(action_i);
          row_d   = row_i;
          col_d   = col_i;
          cend_d  = col_end_i;
          neg_d   = row_end_i < row_i;
          drmag_d = (row_end_i < row_i) ? row_i - row_end_i : row_end_i - row_i;
          idx_d   = '0;
          case (action_i)
            ACT_SET:    if (pix_ok) frame_d[wr_idx] = frame_q[wr_idx] | col_bit(col_i);
            ACT_CLEAR:  if (pix_ok) frame_d[wr_idx] = frame_q[wr_idx] & ~col_bit(col_i);
            ACT_NUMBER: begin
              if (number_i <= 7'd99) begin
                div_req.start    = 1'b1;
                div_req.dividend = number_i;
                div_req.divisor  = DEC_BASE;
              end
            end
            ACT_LINE: begin
              // vertical line is a single pixel
              if (col_end_i == col_i) act_d = ACT_PLOT;
              if (line_ok && (col_end_i != col_i)) begin
                div_req.start    = 1'b1;
                div_req.dividend = '0;
                div_req.divisor  = {1'b0, col_end_i - col_i};
              end
            end
            default: ;
          endcase
        end
      end
      ST_EMIT: begin
        if (out_fire && !last_o) begin
          idx_d = idx_q + 4'd1;
          if (act_q == ACT_LINE) begin
            div_req.start    = 1'b1;
            div_req.dividend = DVD_W'(6'(drmag_q) * 6'(k_next));
            div_req.divisor  = {1'b0, cend_q - col_q};
          end
        end
      end
      default: ;
    endcase
  end

  // line row: truncating signed quotient added to the start row, clamped
  assign line_c  = col_q + idx_q[2:0];
  assign line_r  = neg_q ? $signed({6'b0, row_q}) - $signed({2'b0, div_rsp.quot})
                         : $signed({6'b0, row_q}) + $signed({2'b0, div_rsp.quot});
  assign line_ri = (line_r < 9'sd1) ? 3'd0 :
                   (line_r > 9'sd5) ? 3'd4 : 3'(line_r[2:0] - 3'd1);
  assign sub_idx = idx_q[2:0] - 3'd5;

  // beat payload from the held command state
  always_comb begin
    row_word_o = ROW_ALL_OFF;
    col_word_o = '0;
    last_o     = 1'b1;
    case (act_q)
      ACT_PLOT: begin
        row_word_o = row_sel(row_q - 3'd1);
        col_word_o = col_bit(col_q);
      end
      ACT_SCAN: begin
        row_word_o = row_sel(idx_q[2:0]);
        if (idx_q < 4'(ROWS)) col_word_o = frame_q[ROW_IDX_W'(idx_q)];
        last_o     = idx_q == 4'(ROWS - 1);
      end
      ACT_NUMBER: begin
        last_o = idx_q == 4'd10;
        if (idx_q < 4'd5) begin
          row_word_o = row_sel(idx_q[2:0]);
          col_word_o = {4'b0, glyph(div_rsp.rem, idx_q[2:0])};
        end else if (idx_q < 4'd10) begin
          row_word_o = row_sel(sub_idx);
          col_word_o = {glyph(div_rsp.quot[3:0], sub_idx), 4'b0};
        end
      end
      ACT_LINE: begin
        row_word_o = row_sel(line_ri);
        col_word_o = col_bit(line_c);
        last_o     = line_c == cend_q;
      end
      default: ;
    endcase
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = state_q == ST_EMIT;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      act_q   <= ACT_BLANK;
      idx_q   <= '0;
      for (int i = 0; i < ROWS; i++) frame_q[i] <= '0;
    end else begin
      state_q <= state_d;
      act_q   <= act_d;
      idx_q   <= idx_d;
      frame_q <= frame_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q   <= row_d;
    col_q   <= col_d;
    cend_q  <= cend_d;
    drmag_q <= drmag_d;
    neg_q   <= neg_d;
  end

  `LMCE_ASSERT_IMP(a_div_done_in_div, div_rsp.done, state_q == ST_DIV, "divider done outside DIV")
  `LMCE_ASSERT_NXT(a_scan_emits, in_fire && (action_i == ACT_SCAN), out_valid_o, "scan gave no beat")
  `LMCE_ASSERT_NXT(a_last_frees, out_fire && last_o, !in_stall_o, "input not freed after last beat")

endmodule

@@ bench/lmce_word_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmce_word_checker
// Watches both channels of the LED matrix command engine. It predicts the
// row/column words of every accepted command from its own frame mirror and
// compares each output beat with the oldest predicted word.
// ----------------------------------------------------------------------------
module lmce_word_checker import lmce_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_o,
  input  logic [2:0] action_i,
  input  logic [2:0] row_i,
  input  logic [2:0] col_i,
  input  logic [2:0] row_end_i,
  input  logic [2:0] col_end_i,
  input  logic [6:0] number_i,
  input  logic       out_valid_o,
  input  logic       out_stall_i,
  input  logic [6:0] row_word_o,
  input  logic [6:0] col_word_o,
  input  logic       last_o,
  output int         fail_count_o,
  output int         pending_o
);

  typedef struct packed {
    logic [6:0] row_word;
    logic [6:0] col_word;
    logic       last;
  } matrix_word_t;

  // one octal digit per glyph row, top row first; bit 2 is the left column
  localparam logic [14:0] DIGIT_FONT [10] = '{
    15'o75557, 15'o26227, 15'o25127, 15'o61616, 15'o55711,
    15'o74616, 15'o34757, 15'o71122, 15'o75757, 15'o75716
  };

  matrix_word_t expected_words[$];
  logic [6:0]   frame_mirror [ROWS];
  int           fails;

  // active low, row 1 on bit 4
  function automatic logic [6:0] row_select(input int r);
    return 7'h7F & ~(7'h10 >> (r - 1));
  endfunction

  function automatic logic [6:0] col_mask(input int c);
    return 7'h40 >> (c - 1);
  endfunction

  task automatic predict_words(input logic [2:0] act, input logic [2:0] r,
                               input logic [2:0] c, input logic [2:0] re,
                               input logic [2:0] ce, input logic [6:0] num);
    matrix_word_t words[$];
    bit           pix_ok;
    bit           line_ok;
    int           i;
    int           dr;
    int           dc;
    int           rr;
    int           units;
    int           tens;
    pix_ok  = r >= 1 && r <= ROWS && c >= 1 && c <= COLS;
    line_ok = pix_ok && re >= 1 && re <= ROWS && ce >= 1 && ce <= COLS && ce >= c;
    case (act)
      ACT_PLOT: begin
        if (pix_ok) words.push_back('{row_select(r), col_mask(c), 1'b0});
      end
      ACT_SET: begin
        if (pix_ok) frame_mirror[r - 1] = frame_mirror[r - 1] | col_mask(c);
      end
      ACT_CLEAR: begin
        if (pix_ok) frame_mirror[r - 1] = frame_mirror[r - 1] & ~col_mask(c);
      end
      ACT_SCAN: begin
        for (i = 1; i <= ROWS; i++) words.push_back('{row_select(i), frame_mirror[i - 1], 1'b0});
      end
      ACT_NUMBER: begin
        if (num <= 99) begin
          units = num % 10;
          tens  = num / 10;
          for (i = 0; i < 5; i++)
            words.push_back('{row_select(i + 1), {4'b0, DIGIT_FONT[units][14 - 3 * i -: 3]},
                              1'b0});
          for (i = 0; i < 5; i++)
            words.push_back('{row_select(i + 1), {DIGIT_FONT[tens][14 - 3 * i -: 3], 4'b0},
                              1'b0});
          words.push_back('{ROW_ALL_OFF, 7'h00, 1'b0});
        end
      end
      ACT_LINE: begin
        if (line_ok) begin
          if (ce == c) begin
            // vertical: a single pixel at the start point
            words.push_back('{row_select(r), col_mask(c), 1'b0});
          end else begin
            dr = int'(re) - int'(r);
            dc = int'(ce) - int'(c);
            for (i = int'(c); i <= int'(ce); i++) begin
              rr = int'(r) + (dr * (i - int'(c))) / dc;
              if (rr < 1) rr = 1;
              if (rr > ROWS) rr = ROWS;
              words.push_back('{row_select(rr), col_mask(i), 1'b0});
            end
          end
        end
      end
      ACT_BLANK: begin
        words.push_back('{ROW_ALL_OFF, 7'h00, 1'b0});
      end
      default: begin
      end
    endcase
    if (words.size() > 0) words[words.size() - 1].last = 1'b1;
    foreach (words[k]) expected_words.push_back(words[k]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    matrix_word_t got;
    matrix_word_t want;
    if (!rst_ni) begin
      foreach (frame_mirror[k]) frame_mirror[k] = '0;
      expected_words.delete();
      fails = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        got = '{row_word_o, col_word_o, last_o};
        if (expected_words.size() == 0) begin
          $error("beat with no word pending: row_word %0h col_word %0h last %0b",
                 got.row_word, got.col_word, got.last);
          fails++;
        end else begin
          want = expected_words.pop_front();
          if (got.row_word !== want.row_word) begin
            $error("row_word: expected %0h, got %0h", want.row_word, got.row_word);
            fails++;
          end
          if (got.col_word !== want.col_word) begin
            $error("col_word: expected %0h, got %0h", want.col_word, got.col_word);
            fails++;
          end
          if (got.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, got.last);
            fails++;
          end
        end
      end
      if (in_valid_i && !in_stall_o)
        predict_words(action_i, row_i, col_i, row_end_i, col_end_i, number_i);
    end
    fail_count_o <= fails;
    pending_o    <= expected_words.size();
  end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the LED matrix command engine with directed corner commands and
// then weighted random commands under three idling phases; the checker
// beside the block predicts and compares every output word.
// ----------------------------------------------------------------------------
module tb_top;
  import lmce_pkg::*;

  localparam int         N_CMDS      = 300;
  localparam int         QUIET_LIMIT = 3000;
  localparam int         TAIL_CYCLES = 100;
  localparam logic [2:0] ACT_UNUSED  = 3'd7;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [2:0] action_i    = ACT_PLOT;
  logic [2:0] row_i       = 3'd1;
  logic [2:0] col_i       = 3'd1;
  logic [2:0] row_end_i   = 3'd1;
  logic [2:0] col_end_i   = 3'd1;
  logic [6:0] number_i    = 7'd0;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [6:0] row_word_o;
  logic [6:0] col_word_o;
  logic       last_o;

  int fail_count;
  int pending;
  int tx_idle_pct = 28;
  int rx_idle_pct = 73;
  int quiet_cycles = 0;

  always #5 clk_i = ~clk_i;

  led_matrix_command_engine_unit u_top (.*);

  lmce_word_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .row_i       (row_i),
    .col_i       (col_i),
    .row_end_i   (row_end_i),
    .col_end_i   (col_end_i),
    .number_i    (number_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .row_word_o  (row_word_o),
    .col_word_o  (col_word_o),
    .last_o      (last_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < rx_idle_pct);
  end

  // watchdog: ends the run when neither channel moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // called right after a rising edge; returns at the edge the beat is taken
  task automatic send_cmd(input logic [2:0] act, input logic [2:0] r, input logic [2:0] c,
                          input logic [2:0] re, input logic [2:0] ce,
                          input logic [6:0] num);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    row_i      <= r;
    col_i      <= c;
    row_end_i  <= re;
    col_end_i  <= ce;
    number_i   <= num;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  initial begin
    int         sent;
    int         pick;
    logic [2:0] act;
    logic [2:0] r;
    logic [2:0] c;
    logic [2:0] re;
    logic [2:0] ce;
    logic [6:0] num;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corners
    send_cmd(ACT_SCAN,   3'd1, 3'd1, 3'd1, 3'd1, 7'd0);    // empty frame after reset
    send_cmd(ACT_PLOT,   3'd1, 3'd1, 3'd1, 3'd1, 7'd0);
    send_cmd(ACT_PLOT,   3'd5, 3'd7, 3'd5, 3'd7, 7'd127);
    send_cmd(ACT_SET,    3'd1, 3'd1, 3'd1, 3'd1, 7'd0);
    send_cmd(ACT_SET,    3'd5, 3'd7, 3'd1, 3'd1, 7'd0);
    send_cmd(ACT_SET,    3'd3, 3'd4, 3'd1, 3'd1, 7'd0);
    send_cmd(ACT_CLEAR,  3'd3, 3'd4, 3'd1, 3'd1, 7'd0);
    send_cmd(ACT_SCAN,   3'd7, 3'd7, 3'd7, 3'd7, 7'd127);
    send_cmd(ACT_NUMBER, 3'd1, 3'd1, 3'd1, 3'd1, 7'd0);
    send_cmd(ACT_NUMBER, 3'd1, 3'd1, 3'd1, 3'd1, 7'd99);
    send_cmd(ACT_NUMBER, 3'd1, 3'd1, 3'd1, 3'd1, 7'd57);
    send_cmd(ACT_NUMBER, 3'd1, 3'd1, 3'd1, 3'd1, 7'd100);  // above 99: ignored
    send_cmd(ACT_NUMBER, 3'd1, 3'd1, 3'd1, 3'd1, 7'd127);
    send_cmd(ACT_LINE,   3'd1, 3'd1, 3'd5, 3'd7, 7'd0);
    send_cmd(ACT_LINE,   3'd5, 3'd1, 3'd1, 3'd7, 7'd0);
    send_cmd(ACT_LINE,   3'd2, 3'd4, 3'd5, 3'd4, 7'd0);    // vertical
    send_cmd(ACT_LINE,   3'd1, 3'd5, 3'd3, 3'd2, 7'd0);    // backwards
    send_cmd(ACT_LINE,   3'd0, 3'd1, 3'd6, 3'd3, 7'd0);    // rows out of range
    send_cmd(ACT_BLANK,  3'd0, 3'd0, 3'd0, 3'd0, 7'd0);
    send_cmd(ACT_UNUSED, 3'd2, 3'd2, 3'd2, 3'd2, 7'd5);
    send_cmd(ACT_PLOT,   3'd0, 3'd0, 3'd1, 3'd1, 7'd0);
    send_cmd(ACT_PLOT,   3'd6, 3'd3, 3'd1, 3'd1, 7'd0);
    send_cmd(ACT_SET,    3'd7, 3'd2, 3'd1, 3'd1, 7'd0);
    send_cmd(ACT_CLEAR,  3'd2, 3'd0, 3'd1, 3'd1, 7'd0);
    send_cmd(ACT_SCAN,   3'd1, 3'd1, 3'd1, 3'd1, 7'd0);

    for (sent = 0; sent < N_CMDS; sent++) begin
      if (sent == N_CMDS / 3) begin
        tx_idle_pct = 73;
        rx_idle_pct = 28;
      end else if (sent == 2 * N_CMDS / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if ($urandom_range(99) < 10) begin
        // noise: any bit pattern
        act = 3'($urandom);
        r   = 3'($urandom);
        c   = 3'($urandom);
        re  = 3'($urandom);
        ce  = 3'($urandom);
        num = 7'($urandom);
      end else begin
        pick = $urandom_range(99);
        act  = pick < 15 ? ACT_PLOT  : pick < 40 ? ACT_SET    : pick < 50 ? ACT_CLEAR :
               pick < 65 ? ACT_SCAN  : pick < 75 ? ACT_NUMBER : pick < 95 ? ACT_LINE  :
               ACT_BLANK;
        r    = 3'($urandom_range(ROWS, 1));
        c    = 3'($urandom_range(COLS, 1));
        re   = 3'($urandom_range(ROWS, 1));
        ce   = ($urandom_range(9) == 0) ? 3'($urandom_range(COLS, 1))
                                        : 3'($urandom_range(COLS, c));
        num  = 7'($urandom_range(99));
      end
      send_cmd(act, r, c, re, ce, num);
    end
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
